// ----- sv/spd_pkg.sv -----
// shared types and constants of the shortest path block
package spd_pkg;

	// fixed field widths
	localparam int WEIGHT_W = 16;
	localparam int VERTEX_W = 5;
	localparam int COUNT_W  = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FINISH_VERTEX = 2'd2;

	typedef struct packed {
		logic [WEIGHT_W-1:0] edge_weight;
		logic                edge_present;
	} in_item_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] path_vertex;
		logic                reachable;
		logic                last_of_path;
	} out_item_t;

endpackage

// ----- sv/spd_stream_if.sv -----
// valid/ready stream channel carrying one payload item
interface spd_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- sv/shortest_path_dense_graph.sv -----
// shortest path search over a dense weighted graph loaded as an adjacency matrix
//
// Usage: write vertex_count, start_vertex and finish_vertex on the cfg port while
// the block is idle, then send the n*n matrix entries in row-major order on in_ch,
// one transfer per entry (edge_weight plus edge_present). Entries load at one per
// cycle. After the last entry the block drops in_ch.ready and runs the search on
// its add/compare logic: each round scans all n distances, picks a vertex, then
// relaxes its row through the weight memory's single registered read port, one
// column at a time, reading the weight and then relaxing it. A full search is
// followed by a walk back along the predecessors from the finish vertex.
// The path leaves on out_ch from start to finish, one vertex per transfer, with
// last_of_path on the final one; an unreachable finish gives one transfer with
// reachable low. A stalled receiver holds the output register and the sequencer
// waits; once the last result sits in the output register the block takes the
// next matrix entry. Reset clears the sequencer, the load position, the search
// tables and out_ch.valid; weight memory, path stack and payload are not cleared.
module shortest_path_dense_graph #(
	parameter int MAX_VERTICES = 32,
	parameter int WEIGHT_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [spd_pkg::CFG_DATA_W-1:0] cfg_data,
	spd_stream_if.sink   in_ch,
	spd_stream_if.source out_ch
);

	localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES);
	localparam int EW = (WEIGHT_BITS < spd_pkg::WEIGHT_W) ? WEIGHT_BITS : spd_pkg::WEIGHT_W;
	localparam int DW = EW + IW + 1;
	localparam int PW = IW + 1;
	localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam logic [DW-1:0] DIST_INF = '1;
	localparam logic [PW-1:0] PRED_NONE = '1;

	typedef enum logic [3:0] {
		ST_LOAD, ST_START, ST_SCAN, ST_SELECT, ST_READ, ST_RELAX,
		ST_TRACE, ST_EMIT, ST_UNREACH
	} state_t;

	state_t state_q;

	// configuration registers
	logic [spd_pkg::COUNT_W-1:0]  vcount_q;
	logic [spd_pkg::VERTEX_W-1:0] start_q;
	logic [spd_pkg::VERTEX_W-1:0] finish_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= spd_pkg::COUNT_W'(32);
			start_q  <= '0;
			finish_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				spd_pkg::CFG_VERTEX_COUNT:  vcount_q <= cfg_data;
				spd_pkg::CFG_START_VERTEX:  start_q <= cfg_data[spd_pkg::VERTEX_W-1:0];
				spd_pkg::CFG_FINISH_VERTEX: finish_q <= cfg_data[spd_pkg::VERTEX_W-1:0];
				default: ;
			endcase
		end
	end

	// active vertex count, clamped to one through the maximum
	logic [CW-1:0] n_act;
	logic [AW:0]   total;
	always_comb begin
		if (vcount_q == '0)
			n_act = CW'(1);
		else if (int'(vcount_q) > MAX_VERTICES)
			n_act = CW'(MAX_VERTICES);
		else
			n_act = CW'(vcount_q);
		total = (AW+1)'(n_act) * (AW+1)'(n_act);
	end

	// weight memory with registered read
	logic [EW:0]   wmem [DEPTH];
	logic [EW:0]   rd_q;
	logic [AW:0]   pos_q;
	logic [AW:0]   wr_pos;
	logic [AW:0]   next_pos;
	logic [AW-1:0] rd_addr;
	logic          load_xfer;

	assign load_xfer = in_ch.valid && in_ch.ready;
	assign wr_pos    = (pos_q >= total) ? '0 : pos_q;
	assign next_pos  = wr_pos + (AW+1)'(1);

	always_ff @(posedge clk) begin
		if (load_xfer)
			wmem[wr_pos[AW-1:0]] <= {in_ch.data.edge_weight[EW-1:0], in_ch.data.edge_present};
		rd_q <= wmem[rd_addr];
	end

	// search tables
	logic [DW-1:0] dist_q [MAX_VERTICES];
	logic [PW-1:0] pred_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] vis_q;

	logic [CW-1:0] j_q;
	logic [IW-1:0] best_q;
	logic          found_q;
	logic [DW-1:0] best_d_q;
	logic [AW-1:0] row_base_q;
	logic [CW-1:0] u_q;
	logic [PW-1:0] v_q;
	logic [CW-1:0] len_q;
	logic [IW-1:0] idx_q;

	assign rd_addr = row_base_q + AW'(u_q);

	// add/compare logic: a scan comparator, and an adder and comparator for relaxation
	logic [DW-1:0] cand;
	logic [DW-1:0] cur_d;
	logic [DW-1:0] scan_d;
	logic [IW-1:0] j_idx;
	logic [IW-1:0] u_idx;
	logic          cand_less;
	logic          scan_less;
	assign j_idx     = j_q[IW-1:0];
	assign u_idx     = u_q[IW-1:0];
	assign scan_d    = dist_q[j_idx];
	assign cur_d     = dist_q[u_idx];
	assign cand      = best_d_q + DW'(rd_q[EW:1]);
	assign cand_less = cand < cur_d;
	assign scan_less = scan_d < best_d_q;

	// path stack
	logic [IW-1:0] stack [MAX_VERTICES];
	logic          push;
	logic          out_free;
	logic          emit_load;
	logic          unr_load;
	logic          trace_go;

	assign trace_go  = (v_q != PRED_NONE) && (v_q < PW'(n_act)) && (len_q < n_act);
	assign push      = (state_q == ST_TRACE) && trace_go;
	assign out_free  = !out_ch.valid || out_ch.ready;
	assign emit_load = (state_q == ST_EMIT) && out_free;
	assign unr_load  = (state_q == ST_UNREACH) && out_free;

	always_ff @(posedge clk) begin
		if (push)
			stack[len_q[IW-1:0]] <= v_q[IW-1:0];
	end

	// output register payload
	spd_pkg::out_item_t out_q;
	logic out_valid_q;
	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q.path_vertex  <= spd_pkg::VERTEX_W'(stack[idx_q]);
			out_q.reachable    <= 1'b1;
			out_q.last_of_path <= (idx_q == '0);
		end else if (unr_load) begin
			out_q.path_vertex  <= '0;
			out_q.reachable    <= 1'b0;
			out_q.last_of_path <= 1'b1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
	assign in_ch.ready  = (state_q == ST_LOAD);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			vis_q       <= '0;
			j_q         <= '0;
			best_q      <= '0;
			found_q     <= 1'b0;
			best_d_q    <= '0;
			row_base_q  <= '0;
			u_q         <= '0;
			v_q         <= PRED_NONE;
			len_q       <= '0;
			idx_q       <= '0;
			for (int i = 0; i < MAX_VERTICES; i++) begin
				dist_q[i] <= DIST_INF;
				pred_q[i] <= PRED_NONE;
			end
		end else begin
			if (emit_load || unr_load)
				out_valid_q <= 1'b1;
			else if (out_ch.valid && out_ch.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (load_xfer) begin
						if (next_pos == total) begin
							pos_q   <= '0;
							state_q <= ST_START;
						end else begin
							pos_q <= next_pos;
						end
					end
				end
				ST_START: begin
					if ((CW+1)'(start_q) >= (CW+1)'(n_act) ||
					    (CW+1)'(finish_q) >= (CW+1)'(n_act)) begin
						state_q <= ST_UNREACH;
					end else begin
						for (int i = 0; i < MAX_VERTICES; i++) begin
							dist_q[i] <= (i == int'(start_q)) ? '0 : DIST_INF;
							pred_q[i] <= PRED_NONE;
						end
						vis_q   <= '0;
						j_q     <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				// least unvisited distance, lowest index on a tie
				ST_SCAN: begin
					if (!vis_q[j_idx] && (!found_q || scan_less)) begin
						best_q   <= j_idx;
						best_d_q <= scan_d;
						found_q  <= 1'b1;
					end
					if (j_q == n_act - CW'(1))
						state_q <= ST_SELECT;
					else
						j_q <= j_q + CW'(1);
				end
				ST_SELECT: begin
					if (!found_q || best_d_q == DIST_INF) begin
						v_q     <= PW'(finish_q);
						len_q   <= '0;
						state_q <= (dist_q[IW'(finish_q)] == DIST_INF) ? ST_UNREACH : ST_TRACE;
					end else begin
						vis_q[best_q] <= 1'b1;
						row_base_q <= AW'(best_q) * AW'(n_act);
						u_q        <= '0;
						state_q    <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_RELAX;
				end
				// relax one edge of the chosen row
				ST_RELAX: begin
					if (rd_q[0] && cand_less) begin
						dist_q[u_idx] <= cand;
						pred_q[u_idx] <= PW'(best_q);
					end
					if (u_q == n_act - CW'(1)) begin
						j_q     <= '0;
						found_q <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						u_q     <= u_q + CW'(1);
						state_q <= ST_READ;
					end
				end
				// walk predecessors back from the finish
				ST_TRACE: begin
					if (trace_go) begin
						v_q   <= pred_q[v_q[IW-1:0]];
						len_q <= len_q + CW'(1);
					end else begin
						idx_q   <= IW'(len_q - CW'(1));
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (idx_q == '0)
							state_q <= ST_LOAD;
						else
							idx_q <= idx_q - IW'(1);
					end
				end
				ST_UNREACH: begin
					if (out_free)
						state_q <= ST_LOAD;
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

endmodule

// ----- sv/spd_checker.sv -----
// port-level checks of the shortest path block and their bind
module spd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input spd_pkg::out_item_t out_data
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// an unreachable result is alone and reports vertex zero
	a_unreach_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.reachable |-> out_data.last_of_path &&
		out_data.path_vertex == '0)
		else $error("malformed unreachable result");

	// no matrix entry is taken while a path is still being sent
	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last_of_path |-> !in_ready)
		else $error("input taken during path output");

	// handshake controls are always driven out of reset
	a_ctrl_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(out_valid) && !$isunknown(in_ready))
		else $error("unknown handshake control");

endmodule

bind shortest_path_dense_graph spd_checker u_spd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data)
);

// ----- tb/shortest_path_dense_graph_tb.sv -----
// testbench of the shortest path block: matrix loads, searches and path checks
`timescale 1ns / 100ps

module shortest_path_dense_graph_tb;

	localparam int MAXV = 32;
	localparam int LIMIT_CYCLES = 2000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [spd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [spd_pkg::CFG_DATA_W-1:0] cfg_data;

	spd_stream_if #(.T(spd_pkg::in_item_t)) in_ch ();
	spd_stream_if #(.T(spd_pkg::out_item_t)) out_ch ();

	shortest_path_dense_graph DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// predictor copy of the configuration and the matrix
	logic [5:0] model_count;
	logic [4:0] model_start;
	logic [4:0] model_finish;
	logic [16:0] matrix [MAXV*MAXV];
	int unsigned load_pos;
	spd_pkg::out_item_t path_queue [$];

	int errors;
	int sent_items;
	int checked_results;
	int searches;
	int unreachable_seen;
	longint cycles;
	bit random_gaps;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("shortest_path_dense_graph_tb NOT OK");
			$finish;
		end
	end

	// receiver stall pattern
	int stall_mode;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 199) == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= ($urandom_range(0, 3) != 0);
				default: out_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// compare each result transfer with the oldest expected path vertex
	always @(posedge clk) begin
		spd_pkg::out_item_t got, want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (path_queue.size() == 0) begin
				$error("unexpected result vertex=%0d", got.path_vertex);
				errors++;
			end else begin
				want = path_queue.pop_front();
				checked_results++;
				if (got.path_vertex !== want.path_vertex) begin
					$error("path_vertex expected %0d actual %0d", want.path_vertex,
						got.path_vertex);
					errors++;
				end
				if (got.reachable !== want.reachable) begin
					$error("reachable expected %0d actual %0d", want.reachable,
						got.reachable);
					errors++;
				end
				if (got.last_of_path !== want.last_of_path) begin
					$error("last_of_path expected %0d actual %0d", want.last_of_path,
						got.last_of_path);
					errors++;
				end
			end
		end
	end

	function automatic int unsigned active_n();
		if (model_count == 0)
			return 1;
		if (model_count > MAXV)
			return MAXV;
		return model_count;
	endfunction

	// append one expected result
	function automatic void add_expected(spd_pkg::out_item_t r);
		path_queue.insert(path_queue.size(), r);
	endfunction

	// dijkstra over the stored matrix, queues the expected path
	task automatic predict_path(int unsigned n);
		longint unsigned dist_v [MAXV];
		int pred [MAXV];
		bit seen [MAXV];
		int unsigned stack_v [MAXV];
		int unsigned len, best, v;
		longint unsigned cand;
		spd_pkg::out_item_t r;
		searches++;
		if (model_start >= n || model_finish >= n) begin
			r = '{path_vertex: '0, reachable: 1'b0, last_of_path: 1'b1};
			add_expected(r);
			unreachable_seen++;
			return;
		end
		for (int j = 0; j < MAXV; j++) begin
			dist_v[j] = '1;
			pred[j] = -1;
			seen[j] = 1'b0;
		end
		dist_v[model_start] = 0;
		for (int rnd = 0; rnd < n; rnd++) begin
			best = n;
			for (int j = 0; j < n; j++)
				if (!seen[j] && (best == n || dist_v[j] < dist_v[best]))
					best = j;
			if (best == n || dist_v[best] == '1)
				break;
			seen[best] = 1'b1;
			for (int u = 0; u < n; u++) begin
				if (matrix[best*n+u][0]) begin
					cand = dist_v[best] + matrix[best*n+u][16:1];
					if (cand < dist_v[u]) begin
						dist_v[u] = cand;
						pred[u] = best;
					end
				end
			end
		end
		if (dist_v[model_finish] == '1) begin
			r = '{path_vertex: '0, reachable: 1'b0, last_of_path: 1'b1};
			add_expected(r);
			unreachable_seen++;
			return;
		end
		len = 0;
		v = model_finish;
		while (len < n) begin
			stack_v[len++] = v;
			if (pred[v] < 0)
				break;
			v = pred[v];
		end
		for (int k = 0; k < len; k++) begin
			r.path_vertex = 5'(stack_v[len-1-k]);
			r.reachable = 1'b1;
			r.last_of_path = (k + 1 == len);
			add_expected(r);
		end
	endtask

	// one matrix entry transfer, with bursty gaps when random_gaps is set
	task automatic send_entry(logic [15:0] w, bit present);
		int unsigned n;
		if (random_gaps && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_ch.data <= '{edge_weight: w, edge_present: present};
		in_ch.valid <= 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		n = active_n();
		matrix[load_pos] = {w, present};
		load_pos++;
		sent_items++;
		if (load_pos >= n * n) begin
			load_pos = 0;
			predict_path(n);
		end
	endtask

	task automatic idle_input();
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until no path is pending, then let the search tail drain
	task automatic wait_drained();
		idle_input();
		while (path_queue.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_reg(logic [spd_pkg::CFG_IDX_W-1:0] idx, logic [5:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			spd_pkg::CFG_VERTEX_COUNT: model_count = val;
			spd_pkg::CFG_START_VERTEX: model_start = val[4:0];
			default: model_finish = val[4:0];
		endcase
	endtask

	task automatic set_graph(logic [5:0] n, logic [4:0] s, logic [4:0] f);
		wait_drained();
		write_reg(spd_pkg::CFG_VERTEX_COUNT, n);
		write_reg(spd_pkg::CFG_START_VERTEX, {1'b0, s});
		write_reg(spd_pkg::CFG_FINISH_VERTEX, {1'b0, f});
		cfg_we <= 1'b0;
	endtask

	// random weights, present at the given percentage, sometimes extreme
	task automatic send_random_matrix(int pct_present);
		int unsigned n;
		logic [15:0] w;
		n = active_n();
		for (int i = 0; i < n * n; i++) begin
			case ($urandom_range(0, 9))
				0: w = 16'hFFFF;
				1: w = 16'h0000;
				default: w = 16'($urandom_range(0, 65535));
			endcase
			send_entry(w, $urandom_range(0, 99) < pct_present);
		end
	endtask

	task automatic test_directed();
		// single vertex, start equals finish
		set_graph(6'd1, 5'd0, 5'd0);
		send_entry(16'hFFFF, 1'b1);
		// count zero taken as one
		set_graph(6'd0, 5'd0, 5'd0);
		send_entry(16'h0000, 1'b0);
		// two vertices, max weight chain
		set_graph(6'd2, 5'd0, 5'd1);
		send_entry(16'h0000, 1'b0);
		send_entry(16'hFFFF, 1'b1);
		send_entry(16'h5555, 1'b1);
		send_entry(16'hAAAA, 1'b0);
		// unreachable finish: no edges
		set_graph(6'd2, 5'd1, 5'd0);
		repeat (4) send_entry(16'h0001, 1'b0);
		// finish out of range
		set_graph(6'd2, 5'd0, 5'd31);
		repeat (4) send_entry(16'h0001, 1'b1);
		// start out of range on three vertices
		set_graph(6'd3, 5'd3, 5'd1);
		repeat (9) send_entry(16'h0002, 1'b1);
	endtask

	task automatic test_ties();
		// equal weights everywhere: lowest index wins
		set_graph(6'd3, 5'd2, 5'd0);
		repeat (9) send_entry(16'h0004, 1'b1);
	endtask

	task automatic test_random_small();
		random_gaps = 1'b1;
		for (int g = 0; g < 8; g++) begin
			set_graph(6'($urandom_range(2, 4)), 5'($urandom_range(0, 3)),
				5'($urandom_range(0, 3)));
			send_random_matrix($urandom_range(30, 90));
		end
	endtask

	task automatic test_largest();
		// larger sparse graph, path across the extreme vertices
		set_graph(6'd6, 5'd5, 5'd0);
		send_random_matrix(30);
	endtask

	task automatic test_back_to_back();
		// matrices sent without waiting for the previous path
		set_graph(6'd3, 5'd0, 5'd2);
		random_gaps = 1'b0;
		repeat (3) send_random_matrix(70);
		random_gaps = 1'b1;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		model_count = 6'd32;
		model_start = '0;
		model_finish = '0;
		load_pos = 0;
		errors = 0;
		sent_items = 0;
		checked_results = 0;
		searches = 0;
		unreachable_seen = 0;
		cycles = 0;
		random_gaps = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_ties();
		test_back_to_back();
		test_random_small();
		test_largest();

		wait_drained();
		repeat (200) @(posedge clk);
		if (path_queue.size() != 0) begin
			$error("%0d results still expected", path_queue.size());
			errors++;
		end
		$display("covered %0d entries, %0d searches (%0d unreachable), %0d results",
			sent_items, searches, unreachable_seen, checked_results);
		if (errors == 0)
			$display("shortest_path_dense_graph_tb OK");
		else
			$display("shortest_path_dense_graph_tb NOT OK");
		$finish;
	end

endmodule
